FILE: hdl/csdm_pkg.sv
// ----------------------------------------------------------------------------
// csdm_pkg
// Shared widths, constants and pipeline types for the concentric disk map.
// ----------------------------------------------------------------------------
package csdm_pkg;

    localparam int ANGLE_STAGES = 16;
    localparam int ATAN_LEN = 24;
    localparam int RUN_STAGES = (ANGLE_STAGES < ATAN_LEN) ? ANGLE_STAGES : ATAN_LEN;
    localparam int DIV_STAGES = 16;
    localparam int CW = 34;

    localparam logic [15:0] SCALE_RESET = 16'd4096;
    localparam logic [29:0] PI_OVER_4_Q30 = 30'd843314856;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    function automatic logic [29:0] atan_lut(input int i);
        logic [29:0] v;
        v = 30'd0;
        case (i)
            0: v = 30'h3243F6A8; 1: v = 30'h1DAC6705; 2: v = 30'h0FADBAFC;
            3: v = 30'h07F56EA6; 4: v = 30'h03FEAB76; 5: v = 30'h01FFD55B;
            6: v = 30'h00FFFAAA; 7: v = 30'h007FFF55; 8: v = 30'h003FFFEA;
            9: v = 30'h001FFFFD; 10: v = 30'h000FFFFF; 11: v = 30'h0007FFFF;
            12: v = 30'h0003FFFF; 13: v = 30'h0001FFFF; 14: v = 30'h0000FFFF;
            15: v = 30'h00007FFF; 16: v = 30'h00003FFF; 17: v = 30'h00001FFF;
            18: v = 30'h00000FFF; 19: v = 30'h000007FF; 20: v = 30'h000003FF;
            21: v = 30'h000001FF; 22: v = 30'h000000FF; 23: v = 30'h0000007F;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // item flags carried alongside the data
    typedef struct packed {
        logic x_major;
        logic x_neg;
        logic y_neg;
        logic zero;
    } tag_t;

    // restoring divider cell state
    typedef struct packed {
        tag_t        tag;
        logic [15:0] major;
        logic [31:0] rem;
        logic [15:0] quo;
    } div_t;

    // rotation cell state
    typedef struct packed {
        tag_t            tag;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cz;
    } rot_t;

endpackage

FILE: hdl/csdm_div_cell.sv
// ----------------------------------------------------------------------------
// csdm_div_cell
// One restoring division step of the minor/major ratio.
// ----------------------------------------------------------------------------
module csdm_div_cell (
    input  logic               aclk,
    input  logic               en,
    input  logic [4:0]         bit_idx,
    input  csdm_pkg::div_t     d_in,
    output csdm_pkg::div_t     d_out
);
    csdm_pkg::div_t d_next;
    logic [31:0] trial;

    always_comb begin
        trial = {16'd0, d_in.major} << bit_idx;
        d_next = d_in;
        if (d_in.rem >= trial) begin
            d_next.rem = d_in.rem - trial;
            d_next.quo[bit_idx[3:0]] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_out <= d_next;
        end
    end
endmodule

FILE: hdl/csdm_rot_cell.sv
// ----------------------------------------------------------------------------
// csdm_rot_cell
// One CORDIC rotation micro-step with its own angle constant.
// ----------------------------------------------------------------------------
module csdm_rot_cell (
    input  logic               aclk,
    input  logic               en,
    input  logic [4:0]         shift,
    input  logic [29:0]        atan_c,
    input  csdm_pkg::rot_t     r_in,
    output csdm_pkg::rot_t     r_out
);
    csdm_pkg::rot_t r_next;
    logic signed [csdm_pkg::CW-1:0] dx, dy, da;

    always_comb begin
        dx = r_in.cy >>> shift;
        dy = r_in.cx >>> shift;
        da = $signed({{(csdm_pkg::CW-30){1'b0}}, atan_c});
        r_next = r_in;
        if (!r_in.cz[csdm_pkg::CW-1]) begin
            r_next.cx = r_in.cx - dx;
            r_next.cy = r_in.cy + dy;
            r_next.cz = r_in.cz - da;
        end else begin
            r_next.cx = r_in.cx + dx;
            r_next.cy = r_in.cy - dy;
            r_next.cz = r_in.cz + da;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_out <= r_next;
        end
    end
endmodule

FILE: hdl/concentric_square_to_disk_map_top.sv
// ----------------------------------------------------------------------------
// concentric_square_to_disk_map_top
// Concentric square-to-disk mapping with a configurable output gain.
// ----------------------------------------------------------------------------
// pipeline: input register, 16 divider cells, multiply and start registers,
// RUN_STAGES rotation cells, then scale and output registers
// throughput: one point per cycle; the whole chain advances when the output
// stage is empty or taken
// reset: synchronous active low, clears valid bits and loads scale to 1.0
module concentric_square_to_disk_map_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // x_in[15:0], y_in[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // disk_x[15:0], disk_y[31:16]
    output logic        m_tuser,   // saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    localparam int ND = csdm_pkg::DIV_STAGES;
    localparam int NR = csdm_pkg::RUN_STAGES;
    localparam int CW = csdm_pkg::CW;
    localparam int DEPTH = 1 + ND + 2 + NR + 2;

    logic [15:0] scale_reg;
    logic [DEPTH-1:0] vld_reg;
    logic adv;

    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= csdm_pkg::SCALE_RESET;
            vld_reg <= '0;
        end else begin
            if (cfg_valid) scale_reg <= cfg_data;
            if (adv) vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // stage 0: magnitudes and major/minor split
    logic signed [15:0] x_s, y_s;
    logic [16:0] ax, ay;
    csdm_pkg::div_t d0_reg;
    assign x_s = s_tdata[15:0];
    assign y_s = s_tdata[31:16];
    assign ax = x_s[15] ? 17'(-$signed({x_s[15], x_s})) : {1'b0, x_s};
    assign ay = y_s[15] ? 17'(-$signed({y_s[15], y_s})) : {1'b0, y_s};

    always_ff @(posedge aclk) begin
        if (adv) begin
            d0_reg.tag.x_major <= ay <= ax;
            d0_reg.tag.x_neg <= x_s[15];
            d0_reg.tag.y_neg <= y_s[15];
            d0_reg.tag.zero <= (ax == 17'd0) && (ay == 17'd0);
            // 0x8000 can be major or minor; it then fits 16 bits as unsigned
            d0_reg.major <= (ay <= ax) ? ax[15:0] : ay[15:0];
            d0_reg.rem <= (ay <= ax) ? {ay[15:0], 16'd0} >> 1 : {ax[15:0], 16'd0} >> 1;
            d0_reg.quo <= '0;
        end
    end

    // divider chain, quotient bit 15 down to 0 (minor<<15 / major)
    csdm_pkg::div_t dch [ND+1];
    assign dch[0] = d0_reg;
    genvar g;
    generate
        for (g = 0; g < ND; g++) begin : g_div
            csdm_div_cell u_div (
                .aclk(aclk), .en(adv), .bit_idx(5'(ND-1-g)),
                .d_in(dch[g]), .d_out(dch[g+1])
            );
        end
    endgenerate

    // angle and start radius, registered multiplies
    logic [45:0] z_prod_reg;
    logic [45:0] x_prod_reg;
    csdm_pkg::tag_t t1_reg;
    csdm_pkg::rot_t r0_reg;
    logic [16:0] q_ext;
    assign q_ext = (dch[ND].major == 16'd0) ? 17'd0 : {1'b0, dch[ND].quo};
    always_ff @(posedge aclk) begin
        if (adv) begin
            // ratio of 1 gives quotient 0x8000 which fits 16 bits
            z_prod_reg <= 46'(q_ext[15:0]) * 46'(csdm_pkg::PI_OVER_4_Q30);
            x_prod_reg <= 46'(dch[ND].major) * 46'(csdm_pkg::GAIN_Q30);
            t1_reg <= dch[ND].tag;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            r0_reg.tag <= t1_reg;
            r0_reg.cx <= $signed({3'd0, x_prod_reg[45:15]});
            r0_reg.cy <= '0;
            r0_reg.cz <= $signed({3'd0, z_prod_reg[45:15]});
        end
    end

    csdm_pkg::rot_t rch [NR+1];
    assign rch[0] = r0_reg;
    generate
        for (g = 0; g < NR; g++) begin : g_rot
            csdm_rot_cell u_rot (
                .aclk(aclk), .en(adv), .shift(5'(g)),
                .atan_c(csdm_pkg::atan_lut(g)),
                .r_in(rch[g]), .r_out(rch[g+1])
            );
        end
    endgenerate

    // sign, scale multiply
    csdm_pkg::rot_t rf;
    logic signed [CW-1:0] mx, my;
    logic signed [CW+17-1:0] px_reg, py_reg;
    logic zero_reg;
    assign rf = rch[NR];
    always_comb begin
        mx = rf.tag.x_major ? rf.cx : rf.cy;
        my = rf.tag.x_major ? rf.cy : rf.cx;
        if (rf.tag.x_neg) mx = -mx;
        if (rf.tag.y_neg) my = -my;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg <= (CW+17)'(mx) * $signed({1'b0, scale_reg});
            py_reg <= (CW+17)'(my) * $signed({1'b0, scale_reg});
            zero_reg <= rf.tag.zero;
        end
    end

    // round, saturate, output register
    logic signed [CW+17-1:0] rx, ry;
    logic sx_hi, sx_lo, sy_hi, sy_lo;
    logic [31:0] data_reg;
    logic sat_reg;
    assign rx = (px_reg + (CW+17)'(64'sd67108864)) >>> 27;
    assign ry = (py_reg + (CW+17)'(64'sd67108864)) >>> 27;
    assign sx_hi = rx > (CW+17)'(32767);
    assign sx_lo = rx < -(CW+17)'(32768);
    assign sy_hi = ry > (CW+17)'(32767);
    assign sy_lo = ry < -(CW+17)'(32768);
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (zero_reg) begin
                data_reg <= '0;
                sat_reg <= 1'b0;
            end else begin
                data_reg[15:0] <= sx_hi ? 16'h7FFF : sx_lo ? 16'h8000 : rx[15:0];
                data_reg[31:16] <= sy_hi ? 16'h7FFF : sy_lo ? 16'h8000 : ry[15:0];
                sat_reg <= sx_hi || sx_lo || sy_hi || sy_lo;
            end
        end
    end
    assign m_tdata = data_reg;
    assign m_tuser = sat_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata == 32'd0 |-> !m_tuser)
        else $error("zero result flagged saturated");
endmodule

FILE: tb/concentric_square_to_disk_map_top_test.sv
// ----------------------------------------------------------------------------
// concentric_square_to_disk_map_top_test
// Checks the concentric square-to-disk map against its own bit-exact model:
// a directed table of corner points, then random points under several gains,
// with random stalls on both streams and a result scoreboard.
// ----------------------------------------------------------------------------
module concentric_square_to_disk_map_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic               sat;
    } disk_pt_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 known;
        disk_pt_t           res;
    } point_row_t;

    localparam longint ARCTAN_Q30 [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // x_in[15:0], y_in[31:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // disk_x[15:0], disk_y[31:16]
    logic        m_tuser;   // saturated
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    logic [15:0] gain;
    disk_pt_t    pending_pts[$];
    int          errors;
    int          n_points;
    int          n_results;
    int          n_sat;
    int          idle_cnt;
    bit          stall_on;

    concentric_square_to_disk_map_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // gain the Q15 magnitude by the UQ4.12 gain, round half up to a 16-bit integer and clip
    function automatic logic signed [15:0] gain_round(longint v, logic [15:0] g,
                                                      inout logic sat);
        longint p;
        p = (v * longint'({48'd0, g}) + (64'sd1 <<< 26)) >>> 27;
        if (p > 32767) begin
            sat = 1'b1;
            return 16'sd32767;
        end
        if (p < -32768) begin
            sat = 1'b1;
            return -16'sd32768;
        end
        return p[15:0];
    endfunction

    function automatic disk_pt_t map_point(logic signed [15:0] x, logic signed [15:0] y,
                                           logic [15:0] g);
        disk_pt_t r;
        longint   ax, ay, major, minor, ratio, cx, cy, cz, sx, sy, mx, my;
        bit       x_major;
        ax = (x < 0) ? -longint'(x) : longint'(x);
        ay = (y < 0) ? -longint'(y) : longint'(y);
        r.sat = 1'b0;
        if (ax == 0 && ay == 0) begin
            r.dx = '0;
            r.dy = '0;
            return r;
        end
        x_major = (ay <= ax);
        major = x_major ? ax : ay;
        minor = x_major ? ay : ax;
        ratio = (minor <<< 15) / major;
        cz = (longint'(csdm_pkg::PI_OVER_4_Q30) * ratio) >>> 15;
        cx = (major * longint'(csdm_pkg::GAIN_Q30)) >>> 15;
        cy = 0;
        for (int i = 0; i < csdm_pkg::ANGLE_STAGES && i < 24; i++) begin
            sx = cy >>> i;
            sy = cx >>> i;
            if (cz >= 0) begin
                cx -= sx;
                cy += sy;
                cz -= ARCTAN_Q30[i];
            end else begin
                cx += sx;
                cy -= sy;
                cz += ARCTAN_Q30[i];
            end
        end
        mx = x_major ? cx : cy;
        my = x_major ? cy : cx;
        if (x < 0) mx = -mx;
        if (y < 0) my = -my;
        r.dx = gain_round(mx, g, r.sat);
        r.dy = gain_round(my, g, r.sat);
        return r;
    endfunction

    task automatic write_gain(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        gain = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                              bit known, disk_pt_t res);
        disk_pt_t exp_pt;
        while (stall_on && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        do @(posedge aclk); while (!s_tready);
        if (known) exp_pt = res;
        else exp_pt = map_point(x, y, gain);
        pending_pts.insert(pending_pts.size(), exp_pt);
        n_points++;
    endtask

    // hold the stream until the pipe is empty, then let it settle
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_pts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_coord(int kind);
        case (kind)
            0: return 16'($urandom_range(65535));
            1: return $signed(16'($urandom_range(64))) - 16'sd32;
            2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return $signed(16'($urandom_range(4095))) - 16'sd2048;
        endcase
    endfunction

    initial begin
        point_row_t  corners[$];
        disk_pt_t    zero_pt;
        logic [15:0] gains[6];
        logic signed [15:0] rx, ry;
        int kind;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        gain      = csdm_pkg::SCALE_RESET;
        stall_on  = 1'b1;
        errors    = 0;
        n_points  = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        zero_pt = '{dx: '0, dy: '0, sat: 1'b0};
        // origin first with the reset gain, then extremes and octant edges, origin again last
        corners = '{
            '{x: 16'sd0,      y: 16'sd0,      known: 1, res: zero_pt},
            '{x: 16'sh7FFF,   y: 16'sd0,      known: 0, res: zero_pt},
            '{x: 16'sh8000,   y: 16'sd0,      known: 0, res: zero_pt},
            '{x: 16'sd0,      y: 16'sh7FFF,   known: 0, res: zero_pt},
            '{x: 16'sd0,      y: 16'sh8000,   known: 0, res: zero_pt},
            '{x: 16'sh7FFF,   y: 16'sh7FFF,   known: 0, res: zero_pt},
            '{x: 16'sh8000,   y: 16'sh8000,   known: 0, res: zero_pt},
            '{x: 16'sh8000,   y: 16'sh7FFF,   known: 0, res: zero_pt},
            '{x: 16'sh7FFF,   y: 16'sh8000,   known: 0, res: zero_pt},
            '{x: 16'sd1,      y: 16'sd0,      known: 0, res: zero_pt},
            '{x: -16'sd1,     y: 16'sd1,      known: 0, res: zero_pt},
            '{x: 16'sd1,      y: 16'sh8000,   known: 0, res: zero_pt},
            '{x: 16'sd12000,  y: -16'sd5000,  known: 0, res: zero_pt},
            '{x: -16'sd300,   y: 16'sd20000,  known: 0, res: zero_pt},
            '{x: 16'sd0,      y: 16'sd0,      known: 1, res: zero_pt}
        };
        foreach (corners[i])
            send_point(corners[i].x, corners[i].y, corners[i].known, corners[i].res);
        drain_pipe();

        // extreme gains included; the third phase runs without stalls
        gains = '{16'hFFFF, 16'd0, 16'd4096, 16'd1, 16'($urandom_range(65535)), 16'd8192};
        foreach (gains[p]) begin
            write_gain(gains[p]);
            stall_on = (p != 2);
            for (int n = 0; n < 150; n++) begin
                kind = $urandom_range(9);
                rx = rand_coord(kind % 4);
                ry = rand_coord($urandom_range(3));
                if (kind == 8) ry = $urandom_range(1) ? rx : -rx;
                if (kind == 9) rx = 16'sd0;
                send_point(rx, ry, 1'b0, zero_pt);
            end
            drain_pipe();
        end
        stall_on = 1'b1;

        $display("points sent %0d, results checked %0d, clipped %0d, gains incl. 0 and 0xFFFF",
                 n_points, n_results, n_sat);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !stall_on || ($urandom_range(99) >= 30);
            if (m_tvalid && m_tready) begin
                n_results++;
                if (pending_pts.size() == 0) begin
                    $error("result with nothing expected: tdata %h", m_tdata);
                    errors++;
                end else begin
                    disk_pt_t e;
                    e = pending_pts.pop_front();
                    if (m_tuser) n_sat++;
                    if ($signed(m_tdata[15:0]) !== e.dx) begin
                        $error("disk_x expected %0d got %0d", e.dx, $signed(m_tdata[15:0]));
                        errors++;
                    end
                    if ($signed(m_tdata[31:16]) !== e.dy) begin
                        $error("disk_y expected %0d got %0d", e.dy, $signed(m_tdata[31:16]));
                        errors++;
                    end
                    if (m_tuser !== e.sat) begin
                        $error("saturated expected %0d got %0d", e.sat, m_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    // ends a hung run: counts cycles with no transfer on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

endmodule
